// File: rtl/ffsa_pkg.sv
// shared constants, status codes and payload types of the first-fit segment allocator
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int ADDR_BITS    = 32;

    localparam int OFFSET_W = 32;
    localparam int SIZE_W   = 33;
    localparam int ORDER_W  = 6;
    localparam int ENTRY_W  = OFFSET_W + SIZE_W;

    localparam logic [ORDER_W-1:0] HEAP_ORDER_RST = 6'd26;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_ZERO_SIZE  = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } t_status;

    typedef struct packed {
        logic                action;
        logic [SIZE_W-1:0]   alloc_size;
        logic [OFFSET_W-1:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [2:0]          status;
        logic [OFFSET_W-1:0] seg_start;
        logic [SIZE_W-1:0]   free_left;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        logic    wr_en;
        logic    wr_new;
        logic    pos_clr;
        logic    pos_step;
        logic    commit_alloc;
        logic    commit_free;
        logic    res_load;
        logic    seg_ok;
        t_status status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_free;
        logic zero_size;
        logic over_free;
        logic fit;
        logic tail_ok;
        logic match;
    } t_sts;

endpackage

// File: rtl/ffsa_req_if.sv
// request channel: valid, ready and one request payload
interface ffsa_req_if;
    logic          valid;
    logic          ready;
    ffsa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ffsa_rsp_if.sv
// response channel: valid, ready and one response payload
interface ffsa_rsp_if;
    logic          valid;
    logic          ready;
    ffsa_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ffsa_datapath.sv
// segment table memory, scan position, free total and response register
module ffsa_datapath #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS,
    parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS,
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ffsa_pkg::ORDER_W-1:0]  i_cfg_wr_data,
    input  ffsa_pkg::t_req                i_req_data,
    input  ffsa_pkg::t_cmd                i_cmd,
    input  logic [IW-1:0]                 i_rd_addr,
    input  logic [IW-1:0]                 i_wr_addr,
    output ffsa_pkg::t_sts                o_sts,
    output logic [CW-1:0]                 o_count,
    output ffsa_pkg::t_rsp                o_rsp_data
);

    localparam int FW = (ADDR_BITS + 1 > ffsa_pkg::SIZE_W) ? ADDR_BITS + 1 : ffsa_pkg::SIZE_W;
    localparam int PW = (ADDR_BITS + 2 > 35) ? ADDR_BITS + 2 : 35;
    localparam int OW = ffsa_pkg::OFFSET_W;
    localparam int SW = ffsa_pkg::SIZE_W;

    function automatic logic [FW-1:0] region(input logic [ffsa_pkg::ORDER_W-1:0] ord);
        logic [ffsa_pkg::ORDER_W-1:0] sat;
        sat = (ord > ffsa_pkg::ORDER_W'(ADDR_BITS)) ? ffsa_pkg::ORDER_W'(ADDR_BITS) : ord;
        return FW'(1) << sat;
    endfunction

    logic [ffsa_pkg::ENTRY_W-1:0] mem [MAX_SEGMENTS];

    logic [ffsa_pkg::ORDER_W-1:0] r_order, n_order;
    logic [CW-1:0]                r_count, n_count;
    logic [FW-1:0]                r_free, n_free;
    logic [PW-1:0]                r_pos, n_pos;
    ffsa_pkg::t_req               r_req;
    ffsa_pkg::t_rsp               r_rsp;
    logic [ffsa_pkg::ENTRY_W-1:0] r_rdata;

    logic [OW-1:0]                rd_off;
    logic [SW-1:0]                rd_len;
    logic [PW-1:0]                off_x, size_x, reg_x;
    logic [FW-1:0]                free_sub, free_add;
    logic [ffsa_pkg::ENTRY_W-1:0] wr_data;

    assign rd_off = r_rdata[ffsa_pkg::ENTRY_W-1:SW];
    assign rd_len = r_rdata[SW-1:0];
    assign off_x  = PW'(rd_off);
    assign size_x = PW'(r_req.alloc_size);
    assign reg_x  = PW'(region(r_order));

    assign free_sub = r_free - FW'(r_req.alloc_size);
    assign free_add = r_free + FW'(rd_len);

    assign wr_data = i_cmd.wr_new ? {r_pos[OW-1:0], r_req.alloc_size} : r_rdata;

    always_comb begin
        o_sts.is_free   = (r_req.action == ffsa_pkg::ACT_FREE);
        o_sts.zero_size = (r_req.alloc_size == '0);
        o_sts.over_free = (FW'(r_req.alloc_size) > r_free);
        o_sts.fit       = (off_x >= r_pos) && ((off_x - r_pos) >= size_x);
        o_sts.tail_ok   = !(r_pos > reg_x) && !(size_x > (reg_x - r_pos));
        o_sts.match     = (rd_off == r_req.free_offset);
    end

    assign o_count    = r_count;
    assign o_rsp_data = r_rsp;

    always_comb begin
        n_order = r_order;
        n_count = r_count;
        n_free  = r_free;
        n_pos   = r_pos;
        if (i_cmd.pos_clr) begin
            n_pos = '0;
        end else if (i_cmd.pos_step) begin
            n_pos = off_x + PW'(rd_len);
        end
        if (i_cmd.commit_alloc) begin
            n_count = r_count + CW'(1);
            n_free  = FW'(free_sub[SW-1:0]);
        end else if (i_cmd.commit_free) begin
            n_count = r_count - CW'(1);
            n_free  = FW'(free_add[SW-1:0]);
        end
        // a register write empties the table and refills the free total
        if (i_cfg_wr_en) begin
            n_order = i_cfg_wr_data;
            n_count = '0;
            n_free  = region(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ffsa_pkg::HEAP_ORDER_RST;
            r_count <= '0;
            r_free  <= region(ffsa_pkg::HEAP_ORDER_RST);
        end else begin
            r_order <= n_order;
            r_count <= n_count;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (i_cmd.load_req) begin
            r_req <= i_req_data;
        end
        if (i_cmd.res_load) begin
            r_rsp.status    <= i_cmd.status;
            r_rsp.seg_start <= i_cmd.seg_ok ? r_pos[OW-1:0] : '0;
            r_rsp.free_left <= r_free[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_rd_addr];
        end
        if (i_cmd.wr_en) begin
            mem[i_wr_addr] <= wr_data;
        end
    end

endmodule

// File: rtl/ffsa_ctrl.sv
// sequencer for request checks, first-fit scan, table shifts and response handshake
module ffsa_ctrl #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS,
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output ffsa_pkg::t_cmd o_cmd,
    output logic [IW-1:0]  o_rd_addr,
    output logic [IW-1:0]  o_wr_addr,
    input  ffsa_pkg::t_sts i_sts,
    input  logic [CW-1:0]  i_count
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_TAIL,
        S_SHIFT,
        S_PLACE,
        S_FIND,
        S_DROP,
        S_RESP
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_k, n_k;
    ffsa_pkg::t_status r_status, n_status;
    logic              r_seg_ok, n_seg_ok;
    logic              r_out_valid, n_out_valid;

    logic [CW:0] idx_p1, k_m1, k_m2, k_p1, k_p2, cnt_x, cnt_m1;

    assign idx_p1 = {1'b0, r_idx} + (CW+1)'(1);
    assign k_m1   = {1'b0, r_k} - (CW+1)'(1);
    assign k_m2   = {1'b0, r_k} - (CW+1)'(2);
    assign k_p1   = {1'b0, r_k} + (CW+1)'(1);
    assign k_p2   = {1'b0, r_k} + (CW+1)'(2);
    assign cnt_x  = {1'b0, i_count};
    assign cnt_m1 = cnt_x - (CW+1)'(1);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_k         = r_k;
        n_status    = r_status;
        n_seg_ok    = r_seg_ok;
        n_out_valid = r_out_valid && !i_rsp_ready;
        o_cmd        = '0;
        o_cmd.status = r_status;
        o_cmd.seg_ok = r_seg_ok;
        o_rd_addr    = '0;
        o_wr_addr    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.pos_clr = 1'b1;
                n_idx         = '0;
                n_seg_ok      = 1'b0;
                if (i_sts.is_free) begin
                    if (i_count == '0) begin
                        n_status = ffsa_pkg::ST_NOT_FOUND;
                        n_state  = S_RESP;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        n_state     = S_FIND;
                    end
                end else if (i_sts.zero_size) begin
                    n_status = ffsa_pkg::ST_ZERO_SIZE;
                    n_state  = S_RESP;
                end else if (i_sts.over_free) begin
                    n_status = ffsa_pkg::ST_NO_SPACE;
                    n_state  = S_RESP;
                end else if (i_count >= CW'(MAX_SEGMENTS)) begin
                    n_status = ffsa_pkg::ST_TABLE_FULL;
                    n_state  = S_RESP;
                end else if (i_count == '0) begin
                    n_state = S_TAIL;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.fit) begin
                    // gap found ahead of entry r_idx: open a slot by moving the tail up
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = cnt_m1[IW-1:0];
                    n_k         = i_count;
                    n_state     = S_SHIFT;
                end else begin
                    o_cmd.pos_step = 1'b1;
                    n_idx          = idx_p1[CW-1:0];
                    if (idx_p1 == cnt_x) begin
                        n_state = S_TAIL;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = idx_p1[IW-1:0];
                    end
                end
            end
            S_TAIL: begin
                if (i_sts.tail_ok) begin
                    n_state = S_PLACE;
                end else begin
                    n_status = ffsa_pkg::ST_NO_SPACE;
                    n_state  = S_RESP;
                end
            end
            S_SHIFT: begin
                o_cmd.wr_en = 1'b1;
                o_wr_addr   = r_k[IW-1:0];
                n_k         = k_m1[CW-1:0];
                if (k_m1 == {1'b0, r_idx}) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = k_m2[IW-1:0];
                end
            end
            S_PLACE: begin
                o_cmd.wr_en        = 1'b1;
                o_cmd.wr_new       = 1'b1;
                o_wr_addr          = r_idx[IW-1:0];
                o_cmd.commit_alloc = 1'b1;
                n_status           = ffsa_pkg::ST_OK;
                n_seg_ok           = 1'b1;
                n_state            = S_RESP;
            end
            S_FIND: begin
                if (i_sts.match) begin
                    o_cmd.commit_free = 1'b1;
                    n_status          = ffsa_pkg::ST_OK;
                    n_k               = r_idx;
                    if (idx_p1 < cnt_x) begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = idx_p1[IW-1:0];
                        n_state     = S_DROP;
                    end else begin
                        n_state = S_RESP;
                    end
                end else if (idx_p1 == cnt_x) begin
                    n_status = ffsa_pkg::ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = idx_p1[IW-1:0];
                    n_idx       = idx_p1[CW-1:0];
                end
            end
            S_DROP: begin
                // count already holds the reduced value here
                o_cmd.wr_en = 1'b1;
                o_wr_addr   = r_k[IW-1:0];
                if (k_p1 < cnt_x) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = k_p2[IW-1:0];
                    n_k         = k_p1[CW-1:0];
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_k         <= '0;
            r_status    <= ffsa_pkg::ST_OK;
            r_seg_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_status    <= n_status;
            r_seg_ok    <= n_seg_ok;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rd_en && o_cmd.wr_en) |-> (o_rd_addr != o_wr_addr))
        else $error("table read and write hit the same entry");

    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit_alloc |-> (i_count < CW'(MAX_SEGMENTS)))
        else $error("segment inserted into a full table");

    a_free_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit_free |-> (i_count != '0))
        else $error("segment removed from an empty table");

    a_rsp_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (!r_out_valid || i_rsp_ready))
        else $error("pending response overwritten");

    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit_alloc && o_cmd.commit_free))
        else $error("allocate and free committed together");

endmodule

// File: rtl/first_fit_segment_allocator_unit.sv
// an early reject goes straight from the checks to the response; an allocate scans for a gap,
//   shifts the tail up and inserts, a free searches for the offset and shifts later entries down;
//   a new response also waits while a previous response is still pending
// throughput: one request at a time, the next is taken in the cycle after the response loads;
//   each scan or shift step moves one entry per cycle (one read and one write port)
// reset (synchronous, active low): empty table, heap_order 26, free total = full region
module first_fit_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS,
    parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ffsa_req_if.sink                     i_req,
    ffsa_rsp_if.source                   o_rsp,
    input  logic                         i_cfg_wr_en,
    input  logic [ffsa_pkg::ORDER_W-1:0] i_cfg_wr_data
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    ffsa_pkg::t_cmd cmd;
    ffsa_pkg::t_sts sts;
    logic [IW-1:0]  rd_addr;
    logic [IW-1:0]  wr_addr;
    logic [CW-1:0]  count;

    ffsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .i_sts       (sts),
        .i_count     (count)
    );

    ffsa_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_data    (i_req.data),
        .i_cmd         (cmd),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .o_sts         (sts),
        .o_count       (count),
        .o_rsp_data    (o_rsp.data)
    );

endmodule
